>>> src/md5_pkg.sv
// MD5 package: round constants, shift amounts, initial chaining values.
// No dependencies.
`timescale 1ns / 1ps
package md5_pkg;
   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [31:0] PAD_BYTE = 32'h00000080;

   function automatic logic [31:0] round_const(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
         6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
         6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [3:0] s);
      logic [4:0] r;
      case (s)
         4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
         4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
         4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
         4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
      endcase
      return r;
   endfunction

   // message word index for step i
   function automatic logic [3:0] msg_index(input logic [5:0] i);
      logic [3:0] g;
      case (i[5:4])
         2'd0: g = i[3:0];
         2'd1: g = 4'(5 * i[3:0] + 1);
         2'd2: g = 4'(3 * i[3:0] + 5);
         default: g = 4'(7 * i[3:0]);
      endcase
      return g;
   endfunction

   function automatic logic [31:0] byte_swap(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction
endpackage

>>> src/md5_message_digest.sv
// MD5 digest engine: block buffer memory, word loader, padding and 64-step compression.
// Depends on md5_pkg.
`timescale 1ns / 1ps
//
//  channel | dir | ports                                   | accepted when
//  req     | in  | req_data_word, req_byte_count, req_last_word | req_valid & !req_stall
//  rsp     | out | rsp_digest_word0..3                     | rsp_valid & !rsp_stall
//
//  A word that completes no block is written to the buffer and counted. The sixteenth word of
//  a block starts the compression: a read phase primes the memory read, 64 steps follow with
//  one read each, and the result is then folded into the chain.
//  A last word writes its padding words at one per cycle (up to 15 in its own block, and
//  16 more in a second block when the length does not fit), then compresses; the digest
//  is held in the output register until taken, and a new request is taken meanwhile.
//  Synchronous reset returns the chain words, position and length to their initial values;
//  the block buffer holds no reset and every entry is written before it is read.
module md5_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word0,
   output logic [31:0] rsp_digest_word1,
   output logic [31:0] rsp_digest_word2,
   output logic [31:0] rsp_digest_word3
);
   localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a word
   localparam logic [2:0] ST_PAD  = 3'd1;  // writing padding / length words
   localparam logic [2:0] ST_COMP = 3'd2;  // 64 steps
   localparam logic [2:0] ST_FOLD = 3'd3;  // add into chain
   localparam logic [2:0] ST_OUT  = 3'd4;  // waiting for output register to free

   logic [31:0] mem [16];
   logic [31:0] rd_ff;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  pos_ff, pos_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] ha_ff, hb_ff, hc_ff, hd_ff, ha_in, hb_in, hc_in, hd_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [6:0]  step_ff, step_in;     // step of the word now in rd_ff; bit 6 marks the read phase
   logic        fin_ff, fin_in;       // message ends with this compression
   logic        lenfit_ff, lenfit_in; // padding phase will write the length
   logic        pend80_ff, pend80_in; // 0x80 still owed (full last word)
   logic        ov_ff, ov_in;
   logic [31:0] o0_ff, o1_ff, o2_ff, o3_ff;
   // set while a last word has been taken but its message is not finished
   logic        inmsg_ff;

   logic        we;
   logic [3:0]  wa, ra;
   logic [31:0] wd;
   logic        accept;
   logic        load_out;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = ov_ff;
   assign rsp_digest_word0 = o0_ff;
   assign rsp_digest_word1 = o1_ff;
   assign rsp_digest_word2 = o2_ff;
   assign rsp_digest_word3 = o3_ff;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   // one step datapath
   logic [5:0]  si;
   logic [31:0] f, t, rt;
   logic [4:0]  sh;
   always_comb begin
      si = step_ff[5:0];
      unique case (si[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      t  = a_ff + f + md5_pkg::round_const(si) + rd_ff;
      sh = md5_pkg::rot_amount({si[5:4], si[1:0]});
      rt = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
   end

   always_comb begin
      logic [2:0]  cnt;
      logic [31:0] mask, lw;
      state_in = state_ff; pos_in = pos_ff; len_in = len_ff;
      ha_in = ha_ff; hb_in = hb_ff; hc_in = hc_ff; hd_in = hd_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      step_in = step_ff; fin_in = fin_ff; lenfit_in = lenfit_ff; pend80_in = pend80_ff;
      we = 1'b0; wa = pos_ff; wd = req_data_word; ra = 4'd0;
      load_out = 1'b0;
      cnt = (req_byte_count > 3'd4) ? 3'd4 : req_byte_count;
      mask = 32'((33'd1 << {cnt, 3'b000}) - 33'd1);
      lw = (req_data_word & mask) | (md5_pkg::PAD_BYTE << {cnt[1:0], 3'b000});
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               we = 1'b1;
               pos_in = pos_ff + 4'd1;
               if (!req_last_word) begin
                  len_in = len_ff + 64'd32;
                  if (pos_ff == 4'd15) begin
                     state_in = ST_COMP; step_in = 7'd64; fin_in = 1'b0;
                  end
               end else begin
                  len_in = len_ff + 64'({cnt, 3'b000});
                  pend80_in = (cnt == 3'd4);
                  if (cnt != 3'd4) wd = lw;
                  lenfit_in = (pos_ff <= 4'd12) || (pos_ff == 4'd13 && cnt != 3'd4);
                  if (pos_ff == 4'd15) begin
                     state_in = ST_COMP; step_in = 7'd64; fin_in = 1'b0;
                  end else state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            we = 1'b1;
            pos_in = pos_ff + 4'd1;
            pend80_in = 1'b0;
            if (pend80_ff) wd = md5_pkg::PAD_BYTE;
            else if (lenfit_ff && pos_ff == 4'd14) wd = len_ff[31:0];
            else if (lenfit_ff && pos_ff == 4'd15) wd = len_ff[63:32];
            else wd = 32'd0;
            if (pos_ff == 4'd15) begin
               state_in = ST_COMP; step_in = 7'd64; fin_in = lenfit_ff;
            end
         end
         ST_COMP: begin
            if (step_ff[6]) begin
               // read phase: fetch word for step 0, latch working copy
               ra = md5_pkg::msg_index(6'd0);
               a_in = ha_ff; b_in = hb_ff; c_in = hc_ff; d_in = hd_ff;
               step_in = 7'd0;
            end else begin
               ra = md5_pkg::msg_index(6'(si + 6'd1));
               a_in = d_ff; d_in = c_ff; c_in = b_ff; b_in = b_ff + rt;
               step_in = step_ff + 7'd1;
               if (si == 6'd63) state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            ha_in = ha_ff + a_ff; hb_in = hb_ff + b_ff;
            hc_in = hc_ff + c_ff; hd_in = hd_ff + d_ff;
            if (!fin_ff) begin
               // a full last word or an overflowing length needs another pad block
               state_in = (pend80_ff || (!lenfit_ff && inmsg_ff)) ? ST_PAD : ST_IDLE;
               if (state_in == ST_PAD) lenfit_in = 1'b1;
            end else state_in = ST_OUT;
         end
         default: begin
            if (!ov_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
               ha_in = md5_pkg::INIT_A; hb_in = md5_pkg::INIT_B;
               hc_in = md5_pkg::INIT_C; hd_in = md5_pkg::INIT_D;
               pos_in = 4'd0; len_in = 64'd0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; pos_ff <= 4'd0; len_ff <= 64'd0;
         ha_ff <= md5_pkg::INIT_A; hb_ff <= md5_pkg::INIT_B;
         hc_ff <= md5_pkg::INIT_C; hd_ff <= md5_pkg::INIT_D;
         fin_ff <= 1'b0; lenfit_ff <= 1'b0; pend80_ff <= 1'b0; ov_ff <= 1'b0;
         step_ff <= 7'd0; inmsg_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pos_ff <= pos_in; len_ff <= len_in;
         ha_ff <= ha_in; hb_ff <= hb_in; hc_ff <= hc_in; hd_ff <= hd_in;
         fin_ff <= fin_in; lenfit_ff <= lenfit_in; pend80_ff <= pend80_in;
         step_ff <= step_in;
         if (accept && req_last_word) inmsg_ff <= 1'b1;
         else if (load_out) inmsg_ff <= 1'b0;
         if (load_out) ov_ff <= 1'b1;
         else if (!rsp_stall) ov_ff <= 1'b0;
      end
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      if (load_out) begin
         o0_ff <= md5_pkg::byte_swap(ha_ff); o1_ff <= md5_pkg::byte_swap(hb_ff);
         o2_ff <= md5_pkg::byte_swap(hc_ff); o3_ff <= md5_pkg::byte_swap(hd_ff);
      end
   end
endmodule
